@@ rtl/aie_pkg.sv @@
// Shared types and constants of the arithmetic interval encoder.
package aie_pkg;

    localparam int NUM_ENTRIES = 7;
    localparam int SYM_W       = 8;
    localparam int PROB_W      = 17;
    localparam int ENTRY_W     = SYM_W + PROB_W;
    localparam int EIU_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int IV_W        = 33;
    localparam int CODE_W      = 32;
    localparam int PROD_W      = IV_W + PROB_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST_ENTRY     = CFG_IDX_W'(NUM_ENTRIES - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENTRIES_IN_USE = CFG_IDX_W'(NUM_ENTRIES);

    localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(17'h10000);
    localparam logic [IV_W-1:0]   ONE_Q32 = {1'b1, {(IV_W-1){1'b0}}};

    // Cumulative bounds of one table entry, Q1.16.
    typedef struct packed {
        logic [PROB_W-1:0] cum;
        logic [PROB_W-1:0] top;
    } bound_t;

    // Search result of one accepted symbol.
    typedef struct packed {
        logic              matched;
        logic              last;
        logic [PROB_W-1:0] cum;
        logic [PROB_W-1:0] top;
    } match_t;

endpackage

@@ rtl/aie_cfg.sv @@
// Configuration registers and the derived cumulative bound table.
module aie_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aie_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aie_pkg::ENTRY_W-1:0]         cfg_data,
    output logic [aie_pkg::SYM_W-1:0]           tbl_sym [aie_pkg::NUM_ENTRIES],
    output aie_pkg::bound_t                     tbl_bound [aie_pkg::NUM_ENTRIES],
    output logic [aie_pkg::NUM_ENTRIES-1:0]     tbl_active
);

    logic [aie_pkg::ENTRY_W-1:0]     entry_reg [aie_pkg::NUM_ENTRIES];
    logic [aie_pkg::EIU_W-1:0]       eiu_reg;
    aie_pkg::bound_t                 bound_reg [aie_pkg::NUM_ENTRIES];
    aie_pkg::bound_t                 bound_next [aie_pkg::NUM_ENTRIES];
    logic [aie_pkg::NUM_ENTRIES-1:0] active_reg;
    logic [aie_pkg::NUM_ENTRIES-1:0] active_next;
    logic                            wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < aie_pkg::NUM_ENTRIES; k++) begin
                entry_reg[k] <= '0;
            end
            eiu_reg <= '0;
        end else if (wr_en) begin
            if (cfg_index <= aie_pkg::CFG_IDX_LAST_ENTRY) begin
                entry_reg[cfg_index] <= cfg_data;
            end else if (cfg_index == aie_pkg::CFG_IDX_ENTRIES_IN_USE) begin
                eiu_reg <= cfg_data[aie_pkg::EIU_W-1:0];
            end
        end
    end

    // Saturating prefix sum of the probabilities, rebuilt every cycle.
    always_comb begin
        logic [aie_pkg::PROB_W:0]   sum;
        logic [aie_pkg::PROB_W-1:0] run;
        run = '0;
        for (int k = 0; k < aie_pkg::NUM_ENTRIES; k++) begin
            sum = {1'b0, run}
                + {1'b0, entry_reg[k][aie_pkg::ENTRY_W-1:aie_pkg::SYM_W]};
            bound_next[k].cum = run;
            if (sum > {1'b0, aie_pkg::ONE_Q16}) begin
                bound_next[k].top = aie_pkg::ONE_Q16;
            end else begin
                bound_next[k].top = sum[aie_pkg::PROB_W-1:0];
            end
            run = bound_next[k].top;
            active_next[k] = aie_pkg::EIU_W'(k) < eiu_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < aie_pkg::NUM_ENTRIES; k++) begin
                bound_reg[k] <= '0;
            end
            active_reg <= '0;
        end else begin
            for (int k = 0; k < aie_pkg::NUM_ENTRIES; k++) begin
                bound_reg[k] <= bound_next[k];
            end
            active_reg <= active_next;
        end
    end

    always_comb begin
        for (int k = 0; k < aie_pkg::NUM_ENTRIES; k++) begin
            tbl_sym[k]   = entry_reg[k][aie_pkg::SYM_W-1:0];
            tbl_bound[k] = bound_reg[k];
        end
        tbl_active = active_reg;
    end

endmodule

@@ rtl/aie_match.sv @@
// Input register with the first-match table search.
module aie_match (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [aie_pkg::SYM_W-1:0]       s_tdata,
    input  logic                            s_tlast,
    input  logic [aie_pkg::SYM_W-1:0]       tbl_sym [aie_pkg::NUM_ENTRIES],
    input  aie_pkg::bound_t                 tbl_bound [aie_pkg::NUM_ENTRIES],
    input  logic [aie_pkg::NUM_ENTRIES-1:0] tbl_active,
    input  logic                            advance,
    output logic                            req_valid,
    output aie_pkg::match_t                 req
);

    logic            valid_reg;
    logic            valid_next;
    aie_pkg::match_t req_reg;
    aie_pkg::match_t req_next;
    logic            accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Scan downward so the lowest matching entry wins.
    always_comb begin
        req_next         = '0;
        req_next.last    = s_tlast;
        for (int k = aie_pkg::NUM_ENTRIES - 1; k >= 0; k--) begin
            if (tbl_active[k] && tbl_sym[k] == s_tdata) begin
                req_next.matched = 1'b1;
                req_next.cum     = tbl_bound[k].cum;
                req_next.top     = tbl_bound[k].top;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_next;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

@@ rtl/aie_interval.sv @@
// Interval state update and the code output register.
module aie_interval (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         req_valid,
    input  aie_pkg::match_t              req,
    output logic                         advance,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [aie_pkg::CODE_W-1:0]   m_tdata,
    output logic [0:0]                   m_tuser
);

    logic [aie_pkg::IV_W-1:0]   low_reg;
    logic [aie_pkg::IV_W-1:0]   low_next;
    logic [aie_pkg::IV_W-1:0]   high_reg;
    logic [aie_pkg::IV_W-1:0]   high_next;
    logic                       flag_reg;
    logic                       flag_next;
    logic                       mvalid_reg;
    logic                       mvalid_next;
    logic [aie_pkg::CODE_W-1:0] code_reg;
    logic                       unk_reg;
    logic [aie_pkg::IV_W-1:0]   range;
    logic [aie_pkg::PROD_W-1:0] prod_top;
    logic [aie_pkg::PROD_W-1:0] prod_cum;
    logic [aie_pkg::IV_W:0]     sum_high;
    logic [aie_pkg::IV_W:0]     sum_low;
    logic [aie_pkg::IV_W-1:0]   upd_low;
    logic [aie_pkg::IV_W-1:0]   upd_high;
    logic                       upd_flag;
    logic                       emit;

    // Hold a last request while an earlier code still waits.
    assign advance = req_valid && (!req.last || !mvalid_reg || m_tready);
    assign emit    = advance && req.last;

    assign range    = high_reg - low_reg;
    assign prod_top = aie_pkg::PROD_W'(range) * aie_pkg::PROD_W'(req.top);
    assign prod_cum = aie_pkg::PROD_W'(range) * aie_pkg::PROD_W'(req.cum);
    assign sum_high = {1'b0, low_reg} + prod_top[aie_pkg::PROD_W-1:16];
    assign sum_low  = {1'b0, low_reg} + prod_cum[aie_pkg::PROD_W-1:16];

    always_comb begin
        if (req.matched) begin
            upd_low  = sum_low[aie_pkg::IV_W-1:0];
            upd_high = sum_high[aie_pkg::IV_W-1:0];
        end else begin
            upd_low  = low_reg;
            upd_high = high_reg;
        end
        upd_flag = flag_reg || !req.matched;
    end

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        flag_next = flag_reg;
        if (emit) begin
            low_next  = '0;
            high_next = aie_pkg::ONE_Q32;
            flag_next = 1'b0;
        end else if (advance) begin
            low_next  = upd_low;
            high_next = upd_high;
            flag_next = upd_flag;
        end
        mvalid_next = mvalid_reg && !m_tready;
        if (emit) begin
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg    <= '0;
            high_reg   <= aie_pkg::ONE_Q32;
            flag_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            low_reg    <= low_next;
            high_reg   <= high_next;
            flag_reg   <= flag_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Saturate a final low of exactly one.
    always_ff @(posedge aclk) begin
        if (emit) begin
            code_reg <= upd_low[aie_pkg::IV_W-1] ? '1 : upd_low[aie_pkg::CODE_W-1:0];
            unk_reg  <= upd_flag;
        end
    end

    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = code_reg;
    assign m_tuser[0] = unk_reg;

    a_low_le_high: assert property (@(posedge aclk) disable iff (!aresetn)
        low_reg <= high_reg)
        else $error("interval low above high");

    a_high_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        high_reg <= aie_pkg::ONE_Q32)
        else $error("interval high above one");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (low_reg == '0 && high_reg == aie_pkg::ONE_Q32 && !flag_reg && m_tvalid))
        else $error("interval not cleared after last symbol");

    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !req.last && !req.matched) |=> flag_reg)
        else $error("unmatched symbol did not set flag");

endmodule

@@ rtl/arithmetic_interval_encoder.sv @@
// Arithmetic interval encoder top level: configuration, search and interval update.
//
// Symbols enter on the s_ channel, one per request; s_tlast marks the last
// symbol of a message. Each symbol is looked up in the first entries_in_use
// table entries (first match wins) and narrows the [low, high) interval by
// the entry's cumulative and own probability. On the last symbol one code
// request leaves on the m_ channel: the final low in m_tdata, and in
// m_tuser a flag set if any symbol of the message matched no entry. The
// interval then returns to [0, 1.0). The interval update (subtract, two
// 33x17 multiplies, add) sits combinationally between the input register
// and the interval and code registers. Throughput is one symbol per cycle;
// when m_tready is low the encoder keeps taking symbols that are not last,
// but a last symbol waits in the input register until the pending code
// leaves. The user must write table registers on the cfg_ channel only
// while no message is in flight; the block itself does not enforce this. A
// written symbol applies from its entry register, its bounds and
// entries_in_use after the bound and active registers. Reset (aresetn low,
// synchronous) clears the table, the interval and both channels' valid flags.
module arithmetic_interval_encoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] symbol
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [31:0] code
    output logic [0:0]                        m_tuser,   // [0] unknown_seen
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [aie_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aie_pkg::ENTRY_W-1:0]       cfg_data
);

    logic [aie_pkg::SYM_W-1:0]       tbl_sym [aie_pkg::NUM_ENTRIES];
    aie_pkg::bound_t                 tbl_bound [aie_pkg::NUM_ENTRIES];
    logic [aie_pkg::NUM_ENTRIES-1:0] tbl_active;
    logic                            req_valid;
    aie_pkg::match_t                 req;
    logic                            advance;

    aie_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tbl_sym    (tbl_sym),
        .tbl_bound  (tbl_bound),
        .tbl_active (tbl_active)
    );

    aie_match u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .tbl_sym    (tbl_sym),
        .tbl_bound  (tbl_bound),
        .tbl_active (tbl_active),
        .advance    (advance),
        .req_valid  (req_valid),
        .req        (req)
    );

    aie_interval u_interval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (req_valid),
        .req        (req),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
